// File: rtl/spq_pkg.sv
// Shared types, constants and command/status bundles for the stable priority queue.
package spq_pkg;

   localparam int SPQ_DEPTH_DEFAULT = 16;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_REMOVED  = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] item_value;
      logic signed [15:0] item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic [1:0]         status;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic signed [15:0] pri;
   } slot_type;

   typedef struct packed {
      logic       load_item;
      logic       rd_head;
      logic       rd_prev;
      logic       wr_shift;
      logic       wr_new;
      logic       pop;
      logic       emit;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic is_remove;
      logic empty;
      logic full;
      logic k_zero;
      logic greater;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/stable_min_priority_queue_core.sv
// Top level of the stable minimum priority queue: sequencer plus slot datapath.
//
// Bounded queue of (value, priority) pairs kept in ascending priority order, ties in
// arrival order, held in a circular single-port-write slot memory. One beat in gives
// exactly one result beat. A remove reads the head slot and advances the head pointer.
// An insert walks from the tail toward the head, moving each entry with a larger
// priority back one slot through the memory's registered read port; no final compare
// is needed when every held entry (or none) is larger.
// Insert on full and remove on empty finish with the state untouched.
// A finished result sits in an output register, so req_stall drops as soon as the
// result is loaded, even while rsp_stall holds it.
module stable_min_priority_queue_core import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   spq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/spq_datapath.sv
// Slot memory, head/count/cursor registers and result register of the priority queue.
module spq_datapath import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output stat_type stat,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

   slot_type mem [QUEUE_DEPTH];

   slot_type           rd_data_ff;
   req_type            item_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   k_ff, k_in;
   logic signed [31:0] hold_value_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [PTR_W-1:0] km1;
   logic [PTR_W:0]   k_sum, km1_sum;
   logic [PTR_W:0]   k_wrap, km1_wrap;
   logic [PTR_W-1:0] k_phys, km1_phys;
   logic [PTR_W-1:0] rd_addr, wr_addr;
   logic             rd_en, wr_en;
   slot_type         wr_slot;
   logic [31:0]      cnt_wide;

   assign km1     = k_ff - 1'b1;
   assign k_sum   = {1'b0, head_ff} + {1'b0, k_ff};
   assign km1_sum = {1'b0, head_ff} + {1'b0, km1};
   assign k_wrap   = (k_sum >= DEPTH_P) ? k_sum - DEPTH_P : k_sum;
   assign km1_wrap = (km1_sum >= DEPTH_P) ? km1_sum - DEPTH_P : km1_sum;
   assign k_phys   = k_wrap[PTR_W-1:0];
   assign km1_phys = km1_wrap[PTR_W-1:0];

   assign rd_en   = cmd.rd_head | cmd.rd_prev;
   assign rd_addr = cmd.rd_head ? head_ff : km1_phys;
   assign wr_en   = cmd.wr_shift | cmd.wr_new;
   assign wr_addr = k_phys;
   assign wr_slot = cmd.wr_shift ? rd_data_ff
                                 : slot_type'{val: item_ff.item_value,
                                              pri: item_ff.item_priority};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_slot;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      k_in     = k_ff;
      if (cmd.load_item) begin
         k_in = count_ff[PTR_W-1:0];
      end
      if (cmd.wr_shift) begin
         k_in = km1;
      end
      if (cmd.wr_new) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         count_in = count_ff - 1'b1;
         head_in  = (head_ff == LAST_P) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign cnt_wide = 32'(count_ff);

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.load_item) begin
         item_ff       <= req_data;
         hold_value_ff <= '0;
      end else if (cmd.pop) begin
         hold_value_ff <= rd_data_ff.val;
      end
      if (cmd.emit) begin
         rsp_ff.removed_value <= hold_value_ff;
         rsp_ff.status        <= cmd.status;
         rsp_ff.entry_count   <= cnt_wide[4:0];
      end
   end

   assign stat.is_remove = item_ff.mode;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == DEPTH_C);
   assign stat.k_zero    = (k_ff == '0);
   assign stat.greater   = (rd_data_ff.pri > item_ff.item_priority);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/spq_control.sv
// Sequencer that steps the datapath through insert, remove and result delivery.
module spq_control import spq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_POP    = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_remove) begin
               if (stat.empty) begin
                  status_in = ST_EMPTY;
                  state_in  = S_FIN;
               end else begin
                  cmd.rd_head = 1'b1;
                  state_in    = S_POP;
               end
            end else if (stat.full) begin
               status_in = ST_FULL;
               state_in  = S_FIN;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (stat.k_zero) begin
               cmd.wr_new = 1'b1;
               status_in  = ST_INSERTED;
               state_in   = S_FIN;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.greater) begin
               cmd.wr_shift = 1'b1;
               state_in     = S_SHIFT;
            end else begin
               cmd.wr_new = 1'b1;
               status_in  = ST_INSERTED;
               state_in   = S_FIN;
            end
         end
         S_POP: begin
            cmd.pop   = 1'b1;
            status_in = ST_REMOVED;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_INSERTED;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
